// ===== rtl/ihf_pkg.sv =====
package ihf_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = X_W + Y_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_W    = 22;
  localparam int ROWSUM_W   = 15;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 7;
  localparam int FEAT_W     = 27;
  localparam int SIZE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int TERM_IDX_W = 4;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(112);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(92);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] KIND_VSPLIT = 2'd0;
  localparam logic [1:0] KIND_HSPLIT = 2'd1;
  localparam logic [1:0] KIND_BANDS  = 2'd2;
  localparam logic [1:0] KIND_QUAD   = 2'd3;

  typedef enum logic [2:0] {
    XS_SX = 3'd0,
    XS_EX = 3'd1,
    XS_MX = 3'd2,
    XS_Q1 = 3'd3,
    XS_Q3 = 3'd4
  } xsel_t;

  typedef enum logic [1:0] {
    YS_SY = 2'd0,
    YS_EY = 2'd1,
    YS_MY = 2'd2
  } ysel_t;

  typedef enum logic [2:0] {
    W_P1 = 3'd0,
    W_M1 = 3'd1,
    W_P2 = 3'd2,
    W_M2 = 3'd3,
    W_M4 = 3'd4
  } wgt_t;

  typedef struct packed {
    xsel_t xs;
    ysel_t ys;
    wgt_t  w;
    logic  last;
  } term_t;

  function automatic term_t mk(xsel_t xs, ysel_t ys, wgt_t w, logic last);
    term_t t;
    t.xs   = xs;
    t.ys   = ys;
    t.w    = w;
    t.last = last;
    return t;
  endfunction

  // corner list of each feature kind, one read per entry
  function automatic term_t term_of(logic [1:0] kind, logic [TERM_IDX_W-1:0] idx);
    term_t t;
    t = mk(XS_SX, YS_SY, W_M1, 1'b1);
    unique case (kind)
      KIND_VSPLIT: begin
        case (idx)
          4'd0: t = mk(XS_EX, YS_EY, W_P1, 1'b0);
          4'd1: t = mk(XS_MX, YS_SY, W_P2, 1'b0);
          4'd2: t = mk(XS_SX, YS_EY, W_P1, 1'b0);
          4'd3: t = mk(XS_EX, YS_SY, W_M1, 1'b0);
          4'd4: t = mk(XS_MX, YS_EY, W_M2, 1'b0);
          default: t = mk(XS_SX, YS_SY, W_M1, 1'b1);
        endcase
      end
      KIND_HSPLIT: begin
        case (idx)
          4'd0: t = mk(XS_SX, YS_EY, W_P1, 1'b0);
          4'd1: t = mk(XS_EX, YS_MY, W_P2, 1'b0);
          4'd2: t = mk(XS_SX, YS_SY, W_P1, 1'b0);
          4'd3: t = mk(XS_EX, YS_EY, W_M1, 1'b0);
          4'd4: t = mk(XS_SX, YS_MY, W_M2, 1'b0);
          default: t = mk(XS_EX, YS_SY, W_M1, 1'b1);
        endcase
      end
      KIND_BANDS: begin
        case (idx)
          4'd0: t = mk(XS_Q3, YS_EY, W_P2, 1'b0);
          4'd1: t = mk(XS_Q1, YS_SY, W_P2, 1'b0);
          4'd2: t = mk(XS_EX, YS_SY, W_P1, 1'b0);
          4'd3: t = mk(XS_SX, YS_EY, W_P1, 1'b0);
          4'd4: t = mk(XS_Q3, YS_SY, W_M2, 1'b0);
          4'd5: t = mk(XS_Q1, YS_EY, W_M2, 1'b0);
          4'd6: t = mk(XS_EX, YS_EY, W_M1, 1'b0);
          default: t = mk(XS_SX, YS_SY, W_M1, 1'b1);
        endcase
      end
      KIND_QUAD: begin
        case (idx)
          4'd0: t = mk(XS_EX, YS_MY, W_P2, 1'b0);
          4'd1: t = mk(XS_SX, YS_MY, W_P2, 1'b0);
          4'd2: t = mk(XS_MX, YS_EY, W_P2, 1'b0);
          4'd3: t = mk(XS_MX, YS_SY, W_P2, 1'b0);
          4'd4: t = mk(XS_MX, YS_MY, W_M4, 1'b0);
          4'd5: t = mk(XS_EX, YS_EY, W_M1, 1'b0);
          4'd6: t = mk(XS_SX, YS_EY, W_M1, 1'b0);
          4'd7: t = mk(XS_EX, YS_SY, W_M1, 1'b0);
          default: t = mk(XS_SX, YS_SY, W_M1, 1'b1);
        endcase
      end
      default: t = mk(XS_SX, YS_SY, W_M1, 1'b1);
    endcase
    return t;
  endfunction

  // register value clamped to 1..max
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int unsigned mx);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if ({1'b0, v} > (SIZE_W+1)'(mx)) r = SIZE_W'(mx);
    return r;
  endfunction

endpackage

// ===== rtl/ihf_ifs.sv =====
interface ihf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ihf_pkg::PIX_W-1:0]     pixel_value;
  logic [ihf_pkg::COORD_W-1:0]   start_x;
  logic [ihf_pkg::COORD_W-1:0]   start_y;
  logic [ihf_pkg::COORD_W-1:0]   end_x;
  logic [ihf_pkg::COORD_W-1:0]   end_y;
  logic [1:0]                    feature_kind;

  modport source (output valid, req_type, pixel_value, start_x, start_y, end_x, end_y,
                  feature_kind, input ready);
  modport sink (input valid, req_type, pixel_value, start_x, start_y, end_x, end_y,
                feature_kind, output ready);
endinterface

interface ihf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ihf_pkg::FEAT_W-1:0] feature_value;
  logic                              out_of_range;

  modport source (output valid, feature_value, out_of_range, input ready);
  modport sink (input valid, feature_value, out_of_range, output ready);
endinterface

interface ihf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ihf_pkg::CFG_IDX_W-1:0]     index;
  logic [ihf_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ihf_ram.sv =====
module ihf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/integral_image_haar_features.sv =====
// Pixel load: read of the entry above, then write back; ready again after that.
// Feature query: n = 6, 6, 8 or 9 corner reads for kinds 0..3, then the result goes to
// the output register; one read per cycle through the single read port of the integral store.
// Out-of-range query: no corner reads. One item is in work at a time.
// Reset (rst_n low, synchronous): counters and row sum cleared, size 112 x 92, no result
// pending. The integral store is not cleared; entries are valid once loaded.
module integral_image_haar_features (
  input  logic  clk,
  input  logic  rst_n,
  ihf_in_if.sink     in_ch,
  ihf_out_if.source  out_ch,
  ihf_cfg_if.sink    cfg_ch
);

  localparam int XW = ihf_pkg::X_W;
  localparam int YW = ihf_pkg::Y_W;
  localparam int SW = ihf_pkg::SIZE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PWR   = 5'b00010,
    S_QRUN  = 5'b00100,
    S_QACC  = 5'b01000,
    S_QDONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [SW-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [SW-1:0] eff_w, eff_h;
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [ihf_pkg::ROWSUM_W-1:0] rowsum_r, rowsum_nxt;

  logic [XW-1:0] pix_x_r, pix_x_nxt;
  logic [YW-1:0] pix_y_r, pix_y_nxt;
  logic          pix_top_r, pix_top_nxt;

  logic [XW-1:0] q_sx_r, q_sx_nxt, q_ex_r, q_ex_nxt;
  logic [YW-1:0] q_sy_r, q_sy_nxt, q_ey_r, q_ey_nxt;
  logic [1:0]    q_kind_r, q_kind_nxt;
  logic [ihf_pkg::TERM_IDX_W-1:0] idx_r, idx_nxt;

  logic [ihf_pkg::FEAT_W-1:0] acc_r, acc_nxt;
  logic                       oor_r, oor_nxt;
  logic                       pend_v_r, pend_v_nxt;
  ihf_pkg::wgt_t              pend_w_r, pend_w_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [ihf_pkg::FEAT_W-1:0] out_val_r, out_val_nxt;
  logic                       out_oor_r, out_oor_nxt;

  logic                        ram_we;
  logic [ihf_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ihf_pkg::STORE_W-1:0] ram_wdata, ram_rdata;

  logic in_acc, cfg_acc;
  logic [XW-1:0] x_use, mx, q1, q3, tx;
  logic [YW-1:0] y_use, my, ty;
  logic [XW:0]   sum_x, x_inc;
  logic [YW:0]   sum_y, y_inc;
  logic [XW+1:0] sum_q1, sum_q3;
  logic          wrap;
  logic [ihf_pkg::FEAT_W-1:0] rd_ext;
  ihf_pkg::term_t term;

  assign eff_w = ihf_pkg::clamp_size(width_r, ihf_pkg::MAX_WIDTH);
  assign eff_h = ihf_pkg::clamp_size(height_r, ihf_pkg::MAX_HEIGHT);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.feature_value = out_val_r;
  assign out_ch.out_of_range  = out_oor_r;

  // raster position of the incoming pixel, restarting once past the image
  assign wrap  = ({1'b0, col_r} >= eff_w) || ({1'b0, row_r} >= eff_h);
  assign x_use = wrap ? '0 : col_r;
  assign y_use = wrap ? '0 : row_r;
  assign x_inc = {1'b0, x_use} + (XW+1)'(1);
  assign y_inc = {1'b0, y_use} + (YW+1)'(1);

  // midpoints and quarter points, truncated
  assign sum_x  = {1'b0, q_sx_r} + {1'b0, q_ex_r};
  assign sum_y  = {1'b0, q_sy_r} + {1'b0, q_ey_r};
  assign sum_q1 = ({2'b0, q_sx_r} << 1) + {2'b0, q_sx_r} + {2'b0, q_ex_r};
  assign sum_q3 = ({2'b0, q_ex_r} << 1) + {2'b0, q_ex_r} + {2'b0, q_sx_r};
  assign mx = sum_x[XW:1];
  assign my = sum_y[YW:1];
  assign q1 = sum_q1[XW+1:2];
  assign q3 = sum_q3[XW+1:2];

  assign term = ihf_pkg::term_of(q_kind_r, idx_r);

  always_comb begin
    unique case (term.xs)
      ihf_pkg::XS_SX: tx = q_sx_r;
      ihf_pkg::XS_EX: tx = q_ex_r;
      ihf_pkg::XS_MX: tx = mx;
      ihf_pkg::XS_Q1: tx = q1;
      ihf_pkg::XS_Q3: tx = q3;
      default:        tx = q_sx_r;
    endcase
    unique case (term.ys)
      ihf_pkg::YS_SY: ty = q_sy_r;
      ihf_pkg::YS_EY: ty = q_ey_r;
      ihf_pkg::YS_MY: ty = my;
      default:        ty = q_sy_r;
    endcase
  end

  // row-major store, row pitch MAX_WIDTH (a power of two)
  assign ram_we    = (state_r == S_PWR);
  assign ram_waddr = {pix_y_r, pix_x_r};
  assign ram_wdata = (pix_top_r ? '0 : ram_rdata)
                     + ihf_pkg::STORE_W'(rowsum_r);
  assign ram_raddr = (state_r == S_QRUN) ? {ty, tx} : {y_use - YW'(1), x_use};

  assign rd_ext = ihf_pkg::FEAT_W'(ram_rdata);

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    rowsum_nxt    = rowsum_r;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    pix_top_nxt   = pix_top_r;
    q_sx_nxt      = q_sx_r;
    q_sy_nxt      = q_sy_r;
    q_ex_nxt      = q_ex_r;
    q_ey_nxt      = q_ey_r;
    q_kind_nxt    = q_kind_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    oor_nxt       = oor_r;
    pend_v_nxt    = 1'b0;
    pend_w_nxt    = pend_w_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_oor_nxt   = out_oor_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // fold in the corner read issued last cycle
    if (pend_v_r) begin
      unique case (pend_w_r)
        ihf_pkg::W_P1: acc_nxt = acc_r + rd_ext;
        ihf_pkg::W_M1: acc_nxt = acc_r - rd_ext;
        ihf_pkg::W_P2: acc_nxt = acc_r + (rd_ext << 1);
        ihf_pkg::W_M2: acc_nxt = acc_r - (rd_ext << 1);
        ihf_pkg::W_M4: acc_nxt = acc_r - (rd_ext << 2);
        default:       acc_nxt = acc_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.req_type == ihf_pkg::REQ_PIXEL) begin
          pix_x_nxt   = x_use;
          pix_y_nxt   = y_use;
          pix_top_nxt = (y_use == '0);
          rowsum_nxt  = ((x_use == '0) ? '0 : rowsum_r)
                        + ihf_pkg::ROWSUM_W'(in_ch.pixel_value);
          if (x_inc >= (XW+1)'(eff_w)) begin
            col_nxt = '0;
            row_nxt = (y_inc >= (YW+1)'(eff_h)) ? '0 : y_inc[YW-1:0];
          end else begin
            col_nxt = x_inc[XW-1:0];
            row_nxt = y_use;
          end
          state_nxt = S_PWR;
        end else if (in_acc) begin
          q_sx_nxt   = in_ch.start_x;
          q_sy_nxt   = in_ch.start_y;
          q_ex_nxt   = in_ch.end_x;
          q_ey_nxt   = in_ch.end_y;
          q_kind_nxt = in_ch.feature_kind;
          idx_nxt    = '0;
          acc_nxt    = '0;
          oor_nxt    = ({1'b0, in_ch.start_x} >= eff_w) || ({1'b0, in_ch.end_x} >= eff_w)
                    || ({1'b0, in_ch.start_y} >= eff_h) || ({1'b0, in_ch.end_y} >= eff_h);
          state_nxt  = oor_nxt ? S_QDONE : S_QRUN;
        end
      end
      S_PWR: begin
        state_nxt = S_IDLE;
      end
      S_QRUN: begin
        pend_v_nxt = 1'b1;
        pend_w_nxt = term.w;
        if (term.last) begin
          state_nxt = S_QACC;
        end else begin
          idx_nxt = idx_r + ihf_pkg::TERM_IDX_W'(1);
        end
      end
      S_QACC: begin
        state_nxt = S_QDONE;
      end
      S_QDONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = oor_r ? '0 : acc_r;
          out_oor_nxt   = oor_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a write to the width or height register restarts the raster
    if (cfg_acc) begin
      if (cfg_ch.index == ihf_pkg::REG_IMAGE_WIDTH) begin
        width_nxt  = cfg_ch.data;
        col_nxt    = '0;
        row_nxt    = '0;
        rowsum_nxt = '0;
      end else if (cfg_ch.index == ihf_pkg::REG_IMAGE_HEIGHT) begin
        height_nxt = cfg_ch.data;
        col_nxt    = '0;
        row_nxt    = '0;
        rowsum_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= ihf_pkg::WIDTH_RESET;
      height_r    <= ihf_pkg::HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      rowsum_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      rowsum_r    <= rowsum_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_x_r   <= pix_x_nxt;
    pix_y_r   <= pix_y_nxt;
    pix_top_r <= pix_top_nxt;
    q_sx_r    <= q_sx_nxt;
    q_sy_r    <= q_sy_nxt;
    q_ex_r    <= q_ex_nxt;
    q_ey_r    <= q_ey_nxt;
    q_kind_r  <= q_kind_nxt;
    idx_r     <= idx_nxt;
    acc_r     <= acc_nxt;
    oor_r     <= oor_nxt;
    pend_w_r  <= pend_w_nxt;
    out_val_r <= out_val_nxt;
    out_oor_r <= out_oor_nxt;
  end

  ihf_ram #(
    .WIDTH (ihf_pkg::STORE_W),
    .DEPTH (ihf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTH
  a_pixel_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.req_type == ihf_pkg::REQ_PIXEL) |=> (state_r == S_PWR))
    else $error("pixel load did not move to write back");

  a_col_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.req_type == ihf_pkg::REQ_PIXEL && !cfg_ch.valid)
    |=> ({1'b0, col_r} < eff_w))
    else $error("column counter past image width after a pixel");

  a_read_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == S_QRUN || state_r == S_QACC))
    else $error("corner read pending outside a query");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_of_range) |-> (out_ch.feature_value == '0))
    else $error("out-of-range result carries a nonzero value");
`endif

endmodule

// ===== test/tb_integral_image_haar_features.sv =====
module tb_integral_image_haar_features;
  timeunit 1ns;
  timeprecision 1ps;

  import ihf_pkg::*;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int RANDOM_ITEMS  = 1000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 40;

  typedef struct packed {
    logic                 req;
    logic [PIX_W-1:0]     pix;
    logic [COORD_W-1:0]   sx;
    logic [COORD_W-1:0]   sy;
    logic [COORD_W-1:0]   ex;
    logic [COORD_W-1:0]   ey;
    logic [1:0]           kind;
  } request_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] value;
    logic                     oor;
  } feature_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    request_t              req;
    logic                  typed;
    feature_t              result;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ihf_in_if  in_ch ();
  ihf_out_if out_ch ();
  ihf_cfg_if cfg_ch ();

  integral_image_haar_features uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the block's integral image and raster position
  logic [STORE_W-1:0]  integral_img [DEPTH];
  bit                  loaded [DEPTH];
  logic [ROWSUM_W-1:0] row_sum;
  int                  raster_x;
  int                  raster_y;
  bit                  image_done;
  logic [SIZE_W-1:0]   width_reg;
  logic [SIZE_W-1:0]   height_reg;

  feature_t expected_features [$];
  int       mismatches;
  int       results_seen;
  int       burst_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int used_size(logic [SIZE_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic longint integral_at(int x, int y);
    return longint'(integral_img[y * MAX_WIDTH + x]);
  endfunction

  function automatic void restart_raster();
    raster_x   = 0;
    raster_y   = 0;
    row_sum    = '0;
    image_done = 1'b0;
  endfunction

  function automatic void apply_pixel(logic [PIX_W-1:0] pix);
    int w, h, x, y;
    logic [STORE_W-1:0] above;
    w = used_size(width_reg, MAX_WIDTH);
    h = used_size(height_reg, MAX_HEIGHT);
    x = raster_x;
    y = raster_y;
    if (x >= w || y >= h) begin
      x = 0;
      y = 0;
      row_sum = '0;
    end
    if (x == 0) row_sum = '0;
    row_sum = row_sum + ROWSUM_W'(pix);
    above = (y == 0) ? '0 : integral_img[(y - 1) * MAX_WIDTH + x];
    integral_img[y * MAX_WIDTH + x] = above + STORE_W'(row_sum);
    loaded[y * MAX_WIDTH + x] = 1'b1;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) begin
        y = 0;
        image_done = 1'b1;
      end
    end
    raster_x = x;
    raster_y = y;
  endfunction

  function automatic void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = data;
      restart_raster();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = data;
      restart_raster();
    end
  endfunction

  function automatic feature_t predict_query(request_t r);
    feature_t f;
    int w, h, sx, sy, ex, ey, mx, my, q1, q3;
    longint v;
    w  = used_size(width_reg, MAX_WIDTH);
    h  = used_size(height_reg, MAX_HEIGHT);
    sx = int'(r.sx);
    sy = int'(r.sy);
    ex = int'(r.ex);
    ey = int'(r.ey);
    if (sx >= w || ex >= w || sy >= h || ey >= h) begin
      f.value = '0;
      f.oor   = 1'b1;
      return f;
    end
    mx = (sx + ex) / 2;
    my = (sy + ey) / 2;
    q1 = (3 * sx + ex) / 4;
    q3 = (sx + 3 * ex) / 4;
    case (r.kind)
      KIND_VSPLIT: v = integral_at(ex, ey) + 2 * integral_at(mx, sy) + integral_at(sx, ey)
                     - integral_at(ex, sy) - 2 * integral_at(mx, ey) - integral_at(sx, sy);
      KIND_HSPLIT: v = integral_at(sx, ey) + 2 * integral_at(ex, my) + integral_at(sx, sy)
                     - integral_at(ex, ey) - 2 * integral_at(sx, my) - integral_at(ex, sy);
      KIND_BANDS:  v = 2 * integral_at(q3, ey) + 2 * integral_at(q1, sy)
                     + integral_at(ex, sy) + integral_at(sx, ey)
                     - 2 * integral_at(q3, sy) - 2 * integral_at(q1, ey)
                     - integral_at(ex, ey) - integral_at(sx, sy);
      default:     v = 2 * (integral_at(ex, my) + integral_at(sx, my)
                          + integral_at(mx, ey) + integral_at(mx, sy))
                     - 4 * integral_at(mx, my) - integral_at(ex, ey) - integral_at(sx, ey)
                     - integral_at(ex, sy) - integral_at(sx, sy);
    endcase
    f.value = FEAT_W'(v);
    f.oor   = 1'b0;
    return f;
  endfunction

  // every corner, midpoint and quarter point a query may read must hold a loaded entry
  function automatic bit corners_loaded(request_t r);
    int xs [5];
    int ys [3];
    xs[0] = int'(r.sx);
    xs[1] = int'(r.ex);
    xs[2] = (int'(r.sx) + int'(r.ex)) / 2;
    xs[3] = (3 * int'(r.sx) + int'(r.ex)) / 4;
    xs[4] = (int'(r.sx) + 3 * int'(r.ex)) / 4;
    ys[0] = int'(r.sy);
    ys[1] = int'(r.ey);
    ys[2] = (int'(r.sy) + int'(r.ey)) / 2;
    foreach (xs[i])
      foreach (ys[j])
        if (!loaded[ys[j] * MAX_WIDTH + xs[i]]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic request_t next_request();
    request_t r;
    int w, h, xlim, ylim;
    r.req  = REQ_PIXEL;
    r.pix  = PIX_W'($urandom);
    r.sx   = COORD_W'($urandom);
    r.sy   = COORD_W'($urandom);
    r.ex   = COORD_W'($urandom);
    r.ey   = COORD_W'($urandom);
    r.kind = 2'($urandom);
    if ($urandom_range(0, 9) < 6) return r;
    r.req = REQ_QUERY;
    w = used_size(width_reg, MAX_WIDTH);
    h = used_size(height_reg, MAX_HEIGHT);
    if ($urandom_range(0, 3) == 0) begin
      // full-range corners, mostly beyond the image
      if (r.sx >= w || r.ex >= w || r.sy >= h || r.ey >= h) return r;
      if (corners_loaded(r)) return r;
      r.req = REQ_PIXEL;
      return r;
    end
    if (image_done) begin
      xlim = w - 1;
      ylim = h - 1;
    end else if (raster_y > 0) begin
      xlim = w - 1;
      ylim = raster_y - 1;
    end else begin
      xlim = (raster_x > 0) ? raster_x - 1 : 0;
      ylim = 0;
    end
    for (int t = 0; t < 8; t++) begin
      r.sx = COORD_W'($urandom_range(0, xlim));
      r.ex = COORD_W'($urandom_range(0, xlim));
      r.sy = COORD_W'($urandom_range(0, ylim));
      r.ey = COORD_W'($urandom_range(0, ylim));
      if (corners_loaded(r)) return r;
    end
    r.req = REQ_PIXEL;
    return r;
  endfunction

  function automatic dir_row_t pixel_row(int pix);
    dir_row_t d;
    d = '0;
    d.req.req = REQ_PIXEL;
    d.req.pix = PIX_W'(pix);
    return d;
  endfunction

  function automatic dir_row_t query_row(int sx, int sy, int ex, int ey, logic [1:0] kind,
                                         bit typed, int value, bit oor);
    dir_row_t d;
    d = '0;
    d.req.req      = REQ_QUERY;
    d.req.sx       = COORD_W'(sx);
    d.req.sy       = COORD_W'(sy);
    d.req.ex       = COORD_W'(ex);
    d.req.ey       = COORD_W'(ey);
    d.req.kind     = kind;
    d.typed        = typed;
    d.result.value = FEAT_W'(value);
    d.result.oor   = oor;
    return d;
  endfunction

  function automatic dir_row_t config_row(logic [CFG_IDX_W-1:0] idx, int data);
    dir_row_t d;
    d = '0;
    d.is_cfg   = 1'b1;
    d.reg_idx  = idx;
    d.reg_data = CFG_DATA_W'(data);
    return d;
  endfunction

  task automatic send_item(request_t r, bit typed, feature_t fixed);
    feature_t exp_f;
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= r.req;
    in_ch.pixel_value  <= r.pix;
    in_ch.start_x      <= r.sx;
    in_ch.start_y      <= r.sy;
    in_ch.end_x        <= r.ex;
    in_ch.end_y        <= r.ey;
    in_ch.feature_kind <= r.kind;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (r.req == REQ_PIXEL) apply_pixel(r.pix);
    else begin
      exp_f = typed ? fixed : predict_query(r);
      expected_features = {expected_features, exp_f};
    end
  endtask

  task automatic offer(request_t r);
    bit pause;
    feature_t unused;
    unused = '0;
    pause  = ($urandom_range(0, 99) == 0);
    if (burst_left == 0 || pause) begin
      in_ch.valid <= 1'b0;
      if (pause) begin
        do @(posedge clk); while (expected_features.size() != 0);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 25);
    end
    burst_left--;
    send_item(r, 1'b0, unused);
  endtask

  // drop valid, drain all results, let a pixel write finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_features.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    write_size(idx, data);
  endtask

  initial begin
    dir_row_t dir_rows [$];
    int pix_vals [12];
    request_t r;
    int wv, hv, n, sel, total, phase;

    pix_vals = '{255, 0, 255, 0, 128, 127, 1, 254, 255, 255, 255, 255};
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_PIXEL;
    in_ch.pixel_value  <= '0;
    in_ch.start_x      <= '0;
    in_ch.start_y      <= '0;
    in_ch.end_x        <= '0;
    in_ch.end_y        <= '0;
    in_ch.feature_kind <= KIND_VSPLIT;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_IMAGE_WIDTH;
    cfg_ch.data        <= '0;
    rst_n              <= 1'b0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_raster();
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // corners beyond the reset size of 112 x 92
    dir_rows = {dir_rows, query_row(112, 0, 0, 0, KIND_VSPLIT, 1, 0, 1)};
    dir_rows = {dir_rows, query_row(0, 0, 5, 92, KIND_HSPLIT, 1, 0, 1)};
    dir_rows = {dir_rows, query_row(127, 127, 127, 127, KIND_QUAD, 1, 0, 1)};
    dir_rows = {dir_rows, config_row(REG_IMAGE_WIDTH, 4)};
    dir_rows = {dir_rows, config_row(REG_IMAGE_HEIGHT, 3)};
    foreach (pix_vals[i]) dir_rows = {dir_rows, pixel_row(pix_vals[i])};
    // single point: weights cancel
    dir_rows = {dir_rows, query_row(3, 2, 3, 2, KIND_QUAD, 1, 0, 0)};
    dir_rows = {dir_rows, query_row(0, 0, 3, 2, KIND_VSPLIT, 0, 0, 0)};
    dir_rows = {dir_rows, query_row(0, 0, 3, 2, KIND_HSPLIT, 0, 0, 0)};
    dir_rows = {dir_rows, query_row(0, 0, 3, 2, KIND_BANDS, 0, 0, 0)};
    dir_rows = {dir_rows, query_row(0, 0, 3, 2, KIND_QUAD, 0, 0, 0)};
    // start beyond end
    dir_rows = {dir_rows, query_row(3, 2, 0, 0, KIND_BANDS, 0, 0, 0)};
    dir_rows = {dir_rows, query_row(4, 0, 0, 0, KIND_VSPLIT, 1, 0, 1)};
    dir_rows = {dir_rows, query_row(0, 3, 0, 0, KIND_HSPLIT, 1, 0, 1)};
    // wrap into a new image, then an unknown index must not restart the raster
    dir_rows = {dir_rows, pixel_row(200)};
    dir_rows = {dir_rows, config_row(REG_SPARE_A, 8'h55)};
    dir_rows = {dir_rows, pixel_row(17)};
    dir_rows = {dir_rows, query_row(0, 0, 1, 1, KIND_QUAD, 0, 0, 0)};

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      else send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].result);
    end

    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      sel = (phase < 5) ? phase : $urandom_range(0, 14);
      case (sel)
        0: begin wv = 0;                       hv = $urandom_range(1, 6);  end
        1: begin wv = $urandom_range(129, 255); hv = 1;                    end
        2: begin wv = 1;                       hv = 255;                   end
        3: begin wv = 255;                     hv = 200;                   end
        4: begin wv = MAX_WIDTH;               hv = 2;                     end
        default: begin wv = $urandom_range(1, 12); hv = $urandom_range(1, 10); end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wv));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hv));
      end else begin
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hv));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wv));
      end
      n = used_size(width_reg, MAX_WIDTH) * used_size(height_reg, MAX_HEIGHT)
          + $urandom_range(10, 40);
      if (n > 180) n = 180;
      if (n > RANDOM_ITEMS - total) n = RANDOM_ITEMS - total;
      repeat (n / 2) begin
        r = next_request();
        offer(r);
        total++;
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
      repeat (n - n / 2) begin
        r = next_request();
        offer(r);
        total++;
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_features.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb_integral_image_haar_features OK");
    else $display("tb_integral_image_haar_features NOT OK");
    $finish;
  end

  // result side: check, then choose next ready
  initial begin
    int cyc;
    int hold_left;
    bit hold_done;
    feature_t exp_f;
    out_ch.ready <= 1'b0;
    mismatches   = 0;
    results_seen = 0;
    cyc       = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_features.size() == 0) begin
          mismatches++;
          $error("unexpected result: feature_value %0d out_of_range %0b",
                 out_ch.feature_value, out_ch.out_of_range);
        end else begin
          exp_f = expected_features.pop_front();
          if (out_ch.feature_value !== exp_f.value) begin
            mismatches++;
            $error("feature_value: expected %0d, actual %0d",
                   $signed(exp_f.value), out_ch.feature_value);
          end
          if (out_ch.out_of_range !== exp_f.oor) begin
            mismatches++;
            $error("out_of_range: expected %0b, actual %0b", exp_f.oor, out_ch.out_of_range);
          end
        end
      end
      // hold off once for a long stretch so the input backs up
      if (!hold_done && results_seen == HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb_integral_image_haar_features NOT OK");
    $finish;
  end

endmodule
